/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// generic form: explicit clock and reset
`define CTEU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// short form for modules with the usual clock and reset names
`define CTEU_ASSERT_CLK(label, prop, msg) \
   `CTEU_ASSERT(label, clock, reset, prop, msg)

`else

`define CTEU_ASSERT(label, clk, rst, prop, msg)
`define CTEU_ASSERT_CLK(label, prop, msg)

`endif

`endif

/* sv/cteu_pkg.sv */
// ----------------------------------------------------------------------------
// cteu_pkg
// shared sizes, opcodes and structs for the toy cpu execute unit
// ----------------------------------------------------------------------------
package cteu_pkg;

   localparam int NUM_REGS    = 16;
   localparam int STACK_DEPTH = 16;

   localparam int DATA_W = 32;
   localparam int MODE_W = 4;
   localparam int SEL_W  = 4;

   localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      OP_LOAD = 4'd0,
      OP_MOV  = 4'd1,
      OP_ADD  = 4'd2,
      OP_SUB  = 4'd3,
      OP_CMP  = 4'd4,
      OP_JMP  = 4'd5,
      OP_JE   = 4'd6,
      OP_JNE  = 4'd7,
      OP_PUSH = 4'd8,
      OP_POP  = 4'd9,
      OP_CALL = 4'd10,
      OP_RET  = 4'd11
   } opcode_type;

   // register file write back
   typedef struct packed {
      logic              en;
      logic [RIDX_W-1:0] idx;
      logic [DATA_W-1:0] data;
   } wb_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SEL_W-1:0]  dest_reg;
      logic [DATA_W-1:0] imm_value;
      logic [DATA_W-1:0] current_pc;
   } instr_type;

   typedef struct packed {
      logic              jump_taken;
      logic [DATA_W-1:0] jump_target;
      logic              stack_fault;
      logic              zero_now;
   } result_type;

   function automatic logic reg_ok(logic [SEL_W-1:0] idx);
      return int'(idx) < NUM_REGS;
   endfunction

   function automatic logic [RIDX_W-1:0] reg_index(logic [SEL_W-1:0] idx);
      return RIDX_W'(idx);
   endfunction

endpackage

/* sv/cteu_req_if.sv */
// ----------------------------------------------------------------------------
// cteu_req_if
// instruction channel: one decoded instruction per item
// ----------------------------------------------------------------------------
interface cteu_req_if;
   import cteu_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [SEL_W-1:0]  dest_reg;
   logic [SEL_W-1:0]  src_a_reg;
   logic [SEL_W-1:0]  src_b_reg;
   logic [DATA_W-1:0] imm_value;
   logic [DATA_W-1:0] current_pc;

   modport source (output valid, mode, dest_reg, src_a_reg, src_b_reg, imm_value,
                   current_pc, input ready);
   modport sink (input valid, mode, dest_reg, src_a_reg, src_b_reg, imm_value,
                 current_pc, output ready);
endinterface

/* sv/cteu_rsp_if.sv */
// ----------------------------------------------------------------------------
// cteu_rsp_if
// result channel: jump request, stack fault and zero flag per item
// ----------------------------------------------------------------------------
interface cteu_rsp_if;
   import cteu_pkg::*;

   logic              valid;
   logic              ready;
   logic              jump_taken;
   logic [DATA_W-1:0] jump_target;
   logic              stack_fault;
   logic              zero_now;

   modport source (output valid, jump_taken, jump_target, stack_fault, zero_now,
                   input ready);
   modport sink (input valid, jump_taken, jump_target, stack_fault, zero_now,
                 output ready);
endinterface

/* sv/toy_cpu_execute_unit_core.sv */
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_core
// execute unit of a small cpu: register bank, zero flag and return stack
// ----------------------------------------------------------------------------
// usage
//   req_if carries one decoded instruction per item (valid/ready), rsp_if
//   returns exactly one result item per instruction, in order.
//   operands and instruction are registered when an item is accepted; the
//   item then executes into the result register, which drives rsp_if.
//   throughput: one item per cycle while rsp_if.ready is high; the register
//   read, alu and flag/stack update each sit in a single stage, with the
//   write back bypassed into the operand read so dependent instructions
//   can follow back to back.
//   when rsp_if.ready is low the result register holds, the instruction
//   stage holds behind it and req_if.ready drops once both are full.
//   reset (synchronous, active high) empties the pipe, clears the zero flag
//   and the stack count, and makes every register read as zero until it is
//   written. stack contents are not cleared; entries are only read after
//   a push.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_core (
   input  logic        clock,
   input  logic        reset,
   cteu_req_if.sink    req_if,
   cteu_rsp_if.source  rsp_if
);
   import cteu_pkg::*;

   logic              req_fire;
   wb_type            wb;
   logic [DATA_W-1:0] opa, opb;
   instr_type         req_instr;
   result_type        result;

   assign req_fire = req_if.valid && req_if.ready;

   assign req_instr.mode       = req_if.mode;
   assign req_instr.dest_reg   = req_if.dest_reg;
   assign req_instr.imm_value  = req_if.imm_value;
   assign req_instr.current_pc = req_if.current_pc;

   cteu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_a_idx  (req_if.src_a_reg),
      .rd_b_idx  (req_if.src_b_reg),
      .wb        (wb),
      .rd_a_data (opa),
      .rd_b_data (opb)
   );

   cteu_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_instr (req_instr),
      .opa       (opa),
      .opb       (opb),
      .wb        (wb),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (result)
   );

   assign rsp_if.jump_taken  = result.jump_taken;
   assign rsp_if.jump_target = result.jump_target;
   assign rsp_if.stack_fault = result.stack_fault;
   assign rsp_if.zero_now    = result.zero_now;

endmodule

/* sv/cteu_regfile.sv */
// ----------------------------------------------------------------------------
// cteu_regfile
// register bank with two registered read ports and write-back bypass
// ----------------------------------------------------------------------------
module cteu_regfile (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [cteu_pkg::SEL_W-1:0]   rd_a_idx,
   input  logic [cteu_pkg::SEL_W-1:0]   rd_b_idx,
   input  cteu_pkg::wb_type             wb,
   output logic [cteu_pkg::DATA_W-1:0]  rd_a_data,
   output logic [cteu_pkg::DATA_W-1:0]  rd_b_data
);
   import cteu_pkg::*;

   logic [DATA_W-1:0]   mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic [DATA_W-1:0]   rd_a_ff, rd_b_ff;
   logic [DATA_W-1:0]   rd_a_in, rd_b_in;

   // unwritten entries read as zero, same-cycle write wins
   function automatic logic [DATA_W-1:0] read_port(
      logic [SEL_W-1:0]  idx,
      wb_type            w,
      logic [NUM_REGS-1:0] vld,
      logic [DATA_W-1:0] entry
   );
      logic [RIDX_W-1:0] i;
      i = reg_index(idx);
      if (!reg_ok(idx))
         return '0;
      else if (w.en && w.idx == i)
         return w.data;
      else if (vld[i])
         return entry;
      else
         return '0;
   endfunction

   always_comb begin
      rd_a_in = read_port(rd_a_idx, wb, vld_ff, mem_ff[reg_index(rd_a_idx)]);
      rd_b_in = read_port(rd_b_idx, wb, vld_ff, mem_ff[reg_index(rd_b_idx)]);
   end

   always_ff @(posedge clock) begin
      if (wb.en) begin
         mem_ff[wb.idx] <= wb.data;
      end
      if (rd_en) begin
         rd_a_ff <= rd_a_in;
         rd_b_ff <= rd_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wb.en) begin
         vld_ff[wb.idx] <= 1'b1;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* sv/cteu_exec.sv */
// ----------------------------------------------------------------------------
// cteu_exec
// execute stage: instruction register, alu, flag, stack and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cteu_exec (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  cteu_pkg::instr_type          req_instr,
   input  logic [cteu_pkg::DATA_W-1:0]  opa,
   input  logic [cteu_pkg::DATA_W-1:0]  opb,
   output cteu_pkg::wb_type             wb,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cteu_pkg::result_type         rsp_data
);
   import cteu_pkg::*;

   logic              s1_v_ff;
   instr_type         instr_ff;
   logic              out_v_ff;
   result_type        res_ff;
   result_type        res_in;
   logic              zero_ff, zero_in;
   logic [SCNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] stk_ff [STACK_DEPTH];

   logic              adv;
   logic              full, empty;
   logic [DATA_W-1:0] sum, diff, top_val;
   logic              push, pop;
   logic [DATA_W-1:0] push_data;
   logic              wr_en;
   logic [DATA_W-1:0] wr_data;
   opcode_type        op;

   assign adv       = s1_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !s1_v_ff || adv;

   assign full    = (cnt_ff == SCNT_W'(STACK_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign top_val = stk_ff[SIDX_W'(cnt_ff - 1'b1)];
   assign sum     = opa + opb;
   assign diff    = opa - opb;
   assign op      = opcode_type'(instr_ff.mode);

   always_comb begin
      res_in.jump_taken  = 1'b0;
      res_in.jump_target = '0;
      res_in.stack_fault = 1'b0;
      zero_in            = zero_ff;
      wr_en              = 1'b0;
      wr_data            = instr_ff.imm_value;
      push               = 1'b0;
      pop                = 1'b0;
      push_data          = opa;
      case (op)
         OP_LOAD: begin
            wr_en = 1'b1;
         end
         OP_MOV: begin
            wr_en   = 1'b1;
            wr_data = opa;
         end
         OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = sum;
            zero_in = (sum == '0);
         end
         OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = diff;
            zero_in = (diff == '0);
         end
         OP_CMP: begin
            zero_in = (diff == '0);
         end
         OP_JMP: begin
            res_in.jump_taken  = 1'b1;
            res_in.jump_target = instr_ff.imm_value;
         end
         OP_JE: begin
            if (zero_ff) begin
               res_in.jump_taken  = 1'b1;
               res_in.jump_target = instr_ff.imm_value;
            end
         end
         OP_JNE: begin
            if (!zero_ff) begin
               res_in.jump_taken  = 1'b1;
               res_in.jump_target = instr_ff.imm_value;
            end
         end
         OP_PUSH: begin
            res_in.stack_fault = full;
            push               = !full;
         end
         OP_POP: begin
            // pop from empty stack gives zero
            res_in.stack_fault = empty;
            pop                = !empty;
            wr_en              = 1'b1;
            wr_data            = empty ? '0 : top_val;
         end
         OP_CALL: begin
            res_in.stack_fault = full;
            push               = !full;
            push_data          = instr_ff.current_pc + 1'b1;
            res_in.jump_taken  = 1'b1;
            res_in.jump_target = instr_ff.imm_value;
         end
         OP_RET: begin
            res_in.stack_fault = empty;
            pop                = !empty;
            res_in.jump_taken  = 1'b1;
            res_in.jump_target = empty ? '0 : top_val;
         end
         default: begin
         end
      endcase
      res_in.zero_now = zero_in;

      cnt_in = cnt_ff;
      if (push)
         cnt_in = cnt_ff + 1'b1;
      else if (pop)
         cnt_in = cnt_ff - 1'b1;
   end

   assign wb.en   = adv && wr_en && reg_ok(instr_ff.dest_reg);
   assign wb.idx  = reg_index(instr_ff.dest_reg);
   assign wb.data = wr_data;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         zero_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (req_ready)
            s1_v_ff <= req_valid;
         if (adv)
            out_v_ff <= 1'b1;
         else if (rsp_ready)
            out_v_ff <= 1'b0;
         if (adv) begin
            zero_ff <= zero_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         instr_ff <= req_instr;
      if (adv)
         res_ff <= res_in;
      if (adv && push)
         stk_ff[SIDX_W'(cnt_ff)] <= push_data;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = res_ff;

   `CTEU_ASSERT_CLK(a_cnt_bound, cnt_ff <= SCNT_W'(STACK_DEPTH), "stack count beyond depth")
   `CTEU_ASSERT_CLK(a_adv_out, adv |=> out_v_ff, "executed item lost before result register")
   `CTEU_ASSERT_CLK(a_no_jump_tgt, (out_v_ff && !res_ff.jump_taken) |-> res_ff.jump_target == '0,
      "jump target not zero without jump")
   `CTEU_ASSERT(a_push_cnt, clock, reset,
      (adv && op == OP_PUSH && !full) |=> cnt_ff == SCNT_W'($past(cnt_ff) + 1'b1),
      "push did not raise stack count")
   `CTEU_ASSERT_CLK(a_stall_hold, (s1_v_ff && !adv) |=> s1_v_ff && $stable(instr_ff),
      "stalled instruction changed")

endmodule
